[rtl/dbxs_pkg.sv]
// Shared types and constants of the display bus bit crossbar serializer.
// No dependencies; compiled first.
package dbxs_pkg;

   localparam int MUX_BITS     = 32;
   localparam int SEL_WIDTH    = 5;
   localparam int SELS_PER_REG = 6;
   localparam int REG_COUNT    = 6;
   localparam int CSR_WIDTH    = 31;
   localparam int CSR_IDX_W    = 3;
   localparam int BYTE_W       = 8;
   localparam int QUEUE_DEPTH  = 2;

   typedef logic [CSR_WIDTH-1:0] csr_word_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam int SEL_SHIFT [SELS_PER_REG] = '{0, 5, 10, 16, 21, 26};

   localparam csr_word_type REG_MASK [REG_COUNT] = '{
      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_03FF
   };

   localparam csr_word_type REG_RESET [REG_COUNT] = '{
      31'd176359456, 31'd759767270, 31'd1175402924,
      31'd1591038578, 31'd2006674232, 31'd1022
   };

   // Stage mode codes
   localparam logic [1:0] MODE_ONE = 2'd0;
   localparam logic [1:0] MODE_TWO = 2'd1;

   // Index of the final byte of a word
   localparam logic [1:0] LAST_IDX_ONE  = 2'd0;
   localparam logic [1:0] LAST_IDX_TWO  = 2'd1;
   localparam logic [1:0] LAST_IDX_FOUR = 2'd3;

   typedef struct packed {
      logic [MUX_BITS-1:0] word;
      logic                cmd;
      logic [1:0]          last_idx;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[rtl/dbxs_if.sv]
// Valid/ready channel interfaces of the serializer: word requests and bus bytes.
// Depends on dbxs_pkg.
interface dbxs_req_if;
   import dbxs_pkg::*;
   logic                valid;
   logic                ready;
   logic [MUX_BITS-1:0] tx_word;
   logic                command_flag;
   logic [1:0]          stage_mode;

   modport source (output valid, tx_word, command_flag, stage_mode, input ready);
   modport sink   (input valid, tx_word, command_flag, stage_mode, output ready);
endinterface

interface dbxs_rsp_if;
   import dbxs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] bus_byte;
   logic              command_out;
   logic              last_byte;

   modport source (output valid, bus_byte, command_out, last_byte, input ready);
   modport sink   (input valid, bus_byte, command_out, last_byte, output ready);
endinterface

[rtl/display_bus_bit_crossbar_serializer.sv]
// Display bus bit crossbar serializer: transmit path of an MCU-parallel bus.
// Depends on dbxs_pkg, dbxs_if, dbxs_front, dbxs_queue and dbxs_back.
//
// Usage:
//   req_port  - one transfer per transmit word: tx_word, command_flag and
//               stage_mode (0 one byte, 1 two bytes, 2 or 3 four bytes).
//   rsp_port  - one transfer per bus byte, lowest byte first, with
//               command_out on every byte and last_byte on the final byte.
//   csr_*     - write port for the six crossbar selector registers; write
//               only while no word is in flight. Indexes above five are ignored.
// Data words pass the bit crossbar at acceptance; command words bypass it.
// Path: a word is registered in the queue, then its first byte in the byte
// output register, which drives rsp_port.
// Throughput: one bus byte per cycle while the receiver is ready and a word
// waits, from the single byte output register; 1, 2 or 4 bytes per word.
// Reset: selector registers return to their reset values and the two-word
// queue and output register empty.
// Receiver stall: the output byte holds, the queue fills up to two words,
// counting the word in flight; req_port.ready drops until its last byte goes.
module display_bus_bit_crossbar_serializer (
   input  logic                   clock,
   input  logic                   reset,
   dbxs_req_if.sink               req_port,
   dbxs_rsp_if.source             rsp_port,
   input  logic                   csr_wr_en,
   input  dbxs_pkg::csr_idx_type  csr_index,
   input  dbxs_pkg::csr_word_type csr_wr_data
);
   import dbxs_pkg::*;

   // Front to queue: push a classified word, crossed unless it is a command
   logic         push;
   entry_type    push_entry;
   // Queue to back: head word and occupancy
   entry_type    head;
   q_status_type q_status;
   logic         pop;

   dbxs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   dbxs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // Advance one byte per transfer; drop the head word after its last byte
   dbxs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

[rtl/dbxs_front.sv]
// Front end: selector registers, bit crossbar and byte-count classification.
// Depends on dbxs_pkg and dbxs_if.
module dbxs_front (
   input  logic                   clock,
   input  logic                   reset,
   dbxs_req_if.sink               req_port,
   input  logic                   csr_wr_en,
   input  dbxs_pkg::csr_idx_type  csr_index,
   input  dbxs_pkg::csr_word_type csr_wr_data,
   input  dbxs_pkg::q_status_type q_status,
   output logic                   push,
   output dbxs_pkg::entry_type    push_entry
);
   import dbxs_pkg::*;

   csr_word_type        mux_ff [REG_COUNT];
   csr_word_type        mux_in [REG_COUNT];
   logic [MUX_BITS-1:0] xbar_word;

   // Hold register unless written; drop value bits above its width
   always_comb begin
      for (int r = 0; r < REG_COUNT; r++) begin
         mux_in[r] = mux_ff[r];
      end
      if (csr_wr_en && (csr_index < CSR_IDX_W'(REG_COUNT))) begin
         mux_in[csr_index] = csr_wr_data & REG_MASK[csr_index];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < REG_COUNT; r++) begin
         if (reset) begin
            mux_ff[r] <= REG_RESET[r];
         end else begin
            mux_ff[r] <= mux_in[r];
         end
      end
   end

   // Output bit i takes input bit sel[i]
   always_comb begin
      for (int i = 0; i < MUX_BITS; i++) begin
         xbar_word[i] = req_port.tx_word[
            mux_ff[i / SELS_PER_REG][SEL_SHIFT[i % SELS_PER_REG] +: SEL_WIDTH]];
      end
   end

   assign req_port.ready = !q_status.full;
   assign push           = req_port.valid && !q_status.full;

   always_comb begin
      push_entry.cmd  = req_port.command_flag;
      push_entry.word = req_port.command_flag ? req_port.tx_word : xbar_word;
      if (req_port.stage_mode[1]) begin
         push_entry.last_idx = LAST_IDX_FOUR;
      end else if (req_port.stage_mode == MODE_TWO) begin
         push_entry.last_idx = LAST_IDX_TWO;
      end else begin
         push_entry.last_idx = LAST_IDX_ONE;
      end
   end

endmodule

[rtl/dbxs_queue.sv]
// Two-entry word queue between front and back end.
// Depends on dbxs_pkg.
module dbxs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dbxs_pkg::entry_type    push_entry,
   input  logic                   pop,
   output dbxs_pkg::entry_type    head,
   output dbxs_pkg::q_status_type q_status
);
   import dbxs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty) else $error("pop from empty queue");

endmodule

[rtl/dbxs_back.sv]
// Back end: serializes the head word onto the byte channel, lowest byte first.
// Depends on dbxs_pkg and dbxs_if.
module dbxs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dbxs_pkg::entry_type    head,
   input  dbxs_pkg::q_status_type q_status,
   output logic                   pop,
   dbxs_rsp_if.source             rsp_port
);
   import dbxs_pkg::*;

   logic              advance;
   logic              take;
   logic [1:0]        idx_ff,   idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff,  byte_in;
   logic              cmd_ff,   cmd_in;
   logic              last_ff,  last_in;

   assign advance = !valid_ff || rsp_port.ready;
   assign take    = advance && !q_status.empty;
   assign pop     = take && (idx_ff == head.last_idx);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      cmd_in   = cmd_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         byte_in = head.word[{idx_ff, 3'b000} +: BYTE_W];
         cmd_in  = head.cmd;
         last_in = pop;
         idx_in  = pop ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      cmd_ff  <= cmd_in;
      last_ff <= last_in;
   end

   assign rsp_port.valid       = valid_ff;
   assign rsp_port.bus_byte    = byte_ff;
   assign rsp_port.command_out = cmd_ff;
   assign rsp_port.last_byte   = last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> idx_ff <= head.last_idx) else $error("byte index past word end");
   a_last_resets_idx: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0) else $error("byte index not cleared after last byte");
   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      take |=> last_ff == (idx_ff == 2'd0)) else $error("last mark out of step with index");

endmodule
